/* design/llrc_pkg.sv */
package llrc_pkg;

  // stream and register widths
  localparam int PIX_W      = 8;
  localparam int COL_W      = 12;
  localparam int IDX_W      = 11;
  localparam int ROW_W      = 12;
  localparam int LEN_W      = 7;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;

  localparam int MAX_WIDTH        = 2048;
  localparam int MAX_MODEL_LENGTH = 64;

  // ring of the last pixels of a row, each with its running row prefix sum
  localparam int RING_DEPTH = MAX_MODEL_LENGTH + 1;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int SUM_W      = $clog2(MAX_WIDTH * 255 + 1);
  localparam int RAM_W      = PIX_W + SUM_W;

  localparam int WIN_W      = 14;
  localparam int PROD_W     = LEN_W + PIX_W;
  localparam int RESP_W     = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_LENGTH = 1'd1;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST    = 12'd640;
  localparam logic [LEN_W-1:0] MODEL_LENGTH_RST = 7'd8;

  // one pixel after the input register
  typedef struct packed {
    logic              clear;     // frame start: drop the row before this pixel
    logic              active;    // model length below width
    logic              resp_en;   // a response column is formed
    logic [IDX_W-1:0]  resp_col;
    logic              tail_en;   // row end: zero response of the first tail column
    logic [IDX_W-1:0]  tail_col;
    logic              last;
    logic [ROW_W-1:0]  row;
    logic [LEN_W-1:0]  len;
    logic [SUM_W-1:0]  prefix;
  } s1_t;

endpackage

/* design/llrc_pix_if.sv */
interface llrc_pix_if import llrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

/* design/llrc_res_if.sv */
interface llrc_res_if import llrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [IDX_W-1:0] center_col;
  logic             found;

  modport source (output valid, output row_index, output center_col, output found,
                  input ready);
  modport sink   (input valid, input row_index, input center_col, input found,
                  output ready);
endinterface

/* design/llrc_ram.sv */
module llrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/llrc_front.sv */
module llrc_front import llrc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [PIX_W-1:0]   pixel,
  input  logic               frame_start,
  input  logic [COL_W-1:0]   width,
  input  logic [LEN_W-1:0]   len,
  input  logic               active,
  input  logic               stall,
  output s1_t                s1_r,
  output logic               s1_valid_r,
  output logic [RING_AW-1:0] ram_waddr,
  output logic [RAM_W-1:0]   ram_wdata,
  output logic [RING_AW-1:0] ram_raddr
);

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [RING_AW-1:0] ptr_r, ptr_nxt;
  logic [SUM_W-1:0]   sum_r;

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [RING_AW-1:0] ptr;
  logic [COL_W-1:0]   len_c;
  logic [COL_W-1:0]   resp_diff;
  logic [COL_W-1:0]   tail_diff;
  logic [RING_AW:0]   ptr_e, len_e, rd_e;
  logic               first;
  logic               last;
  s1_t                s1_nxt;

  always_comb begin
    first    = frame_start || (col_r == '0);
    col      = frame_start ? '0 : col_r;
    row      = frame_start ? '0 : row_r;
    ptr      = first ? '0 : ptr_r;
    len_c    = COL_W'(len);
    last     = col >= (width - COL_W'(1));

    resp_diff = col - len_c;
    tail_diff = width - len_c;

    // read address of column (col - len) modulo the ring depth
    ptr_e = (RING_AW+1)'(ptr);
    len_e = (RING_AW+1)'(len);
    if (ptr_e >= len_e) begin
      rd_e = ptr_e - len_e;
    end else begin
      rd_e = ptr_e + (RING_AW+1)'(RING_DEPTH) - len_e;
    end
    ram_raddr = rd_e[RING_AW-1:0];

    s1_nxt.clear    = frame_start;
    s1_nxt.active   = active;
    s1_nxt.resp_en  = active && (col >= len_c);
    s1_nxt.resp_col = resp_diff[IDX_W-1:0];
    s1_nxt.tail_en  = active && last && (len != '0);
    s1_nxt.tail_col = tail_diff[IDX_W-1:0];
    s1_nxt.last     = last;
    s1_nxt.row      = row;
    s1_nxt.len      = len;
    s1_nxt.prefix   = first ? SUM_W'(pixel) : sum_r + SUM_W'(pixel);

    ram_waddr = ptr;
    ram_wdata = {pixel, s1_nxt.prefix};

    col_nxt = last ? '0 : col + COL_W'(1);
    row_nxt = last ? row + ROW_W'(1) : row;
    if (last || (ptr == RING_AW'(RING_DEPTH - 1))) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr + RING_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      ptr_r      <= '0;
      sum_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        ptr_r <= ptr_nxt;
        sum_r <= s1_nxt.prefix;
      end
      if (!stall) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

/* design/llrc_extract.sv */
module llrc_extract import llrc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  s1_t              s1,
  input  logic             s1_valid,
  input  logic [RAM_W-1:0] ram_rdata,
  output logic             stall,
  llrc_res_if.source       out_m
);

  typedef struct packed {
    logic signed [RESP_W-1:0] max_v;
    logic signed [RESP_W-1:0] min_v;
    logic [IDX_W-1:0]         max_c;
    logic [IDX_W-1:0]         min_c;
    logic                     max_set;
    logic                     min_set;
  } ext_t;

  function automatic ext_t take(ext_t e, logic [IDX_W-1:0] col,
                                logic signed [RESP_W-1:0] v);
    ext_t r;
    r = e;
    if (col == '0) begin
      // column 0 only seeds the running values
      r.max_v = v;
      r.min_v = v;
    end else begin
      if (v > e.max_v) begin
        r.max_v   = v;
        r.max_c   = col;
        r.max_set = 1'b1;
      end
      if (v < e.min_v) begin
        r.min_v   = v;
        r.min_c   = col;
        r.min_set = 1'b1;
      end
    end
    return r;
  endfunction

  ext_t ext_r, ext_nxt;
  ext_t e0, e1, e2;

  logic                     out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]         row_index_r;
  logic [IDX_W-1:0]         center_col_r;
  logic                     found_r;

  logic [PIX_W-1:0]         pix_j;
  logic [SUM_W-1:0]         prefix_j;
  logic [SUM_W-1:0]         win_full;
  logic [WIN_W-1:0]         win;
  logic [PROD_W-1:0]        prod;
  logic signed [RESP_W-1:0] resp;
  logic [IDX_W:0]           mid_sum;
  logic                     found;
  logic                     fire;

  always_comb begin
    {pix_j, prefix_j} = ram_rdata;
    // sum of the len pixels after column j, from two prefix sums
    win_full = s1.prefix - prefix_j;
    win      = win_full[WIN_W-1:0];
    prod     = PROD_W'(s1.len) * PROD_W'(pix_j);
    if (s1.len == '0) begin
      resp = '0;
    end else begin
      resp = $signed(RESP_W'(prod)) - $signed(RESP_W'(win));
    end

    e0 = s1.clear ? ext_t'('0) : ext_r;
    e1 = s1.resp_en ? take(e0, s1.resp_col, resp) : e0;
    e2 = s1.tail_en ? take(e1, s1.tail_col, '0) : e1;

    found   = s1.active && e2.max_set && e2.min_set;
    mid_sum = (IDX_W+1)'(e2.max_c) + (IDX_W+1)'(e2.min_c);

    stall = s1_valid && s1.last && out_valid_r && !out_m.ready;
    fire  = s1_valid && !stall;

    ext_nxt = ext_r;
    if (fire) begin
      ext_nxt = s1.last ? ext_t'('0) : e2;
    end

    out_valid_nxt = out_valid_r && !out_m.ready;
    if (fire && s1.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ext_r       <= ext_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1.last) begin
      row_index_r  <= s1.row;
      center_col_r <= found ? mid_sum[IDX_W:1] : '0;
      found_r      <= found;
    end
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.row_index  = row_index_r;
  assign out_m.center_col = center_col_r;
  assign out_m.found      = found_r;

  a_row_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1.last |=> out_valid_r)
    else $error("row end did not load the result register");

  a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1.last |=> !ext_r.max_set && !ext_r.min_set)
    else $error("extrema not cleared after row end");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    ext_r.max_v >= ext_r.min_v)
    else $error("running maximum below running minimum");

  a_no_col0: assert property (@(posedge clk) disable iff (!rst_n)
    (ext_r.max_set |-> ext_r.max_c != '0) and (ext_r.min_set |-> ext_r.min_c != '0))
    else $error("column 0 recorded as an extremum column");

endmodule

/* design/laser_line_row_center_core.sv */
// result path: the row's last pixel passes the input register (registered ring read
//   side by side), then its row result is loaded into the output register once free
// throughput: one pixel per cycle; only a held row result under back-pressure stalls
// reset: rst_n synchronous active low; clears counters, extrema, valids and sets
//   row_width to 640, model_length to 8; the pixel ring is not cleared
module laser_line_row_center_core import llrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  llrc_pix_if.sink             in_s,
  llrc_res_if.source           out_m,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [CFG_W-1:0] row_width_r;
  logic [LEN_W-1:0] model_length_r;

  // clamped working values
  logic [COL_W-1:0] width;
  logic [LEN_W-1:0] len;
  logic             active;

  logic               accept;
  logic               stall;
  s1_t                s1;
  logic               s1_valid;
  logic [RING_AW-1:0] ram_waddr;
  logic [RING_AW-1:0] ram_raddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [RAM_W-1:0]   ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= ROW_WIDTH_RST;
      model_length_r <= MODEL_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROW_WIDTH:    row_width_r    <= cfg_data;
        REG_MODEL_LENGTH: model_length_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // width held to 2..MAX_WIDTH, model length to at most MAX_MODEL_LENGTH
  always_comb begin
    priority if (row_width_r < COL_W'(2)) begin
      width = COL_W'(2);
    end else if (row_width_r > COL_W'(MAX_WIDTH)) begin
      width = COL_W'(MAX_WIDTH);
    end else begin
      width = row_width_r;
    end
    if (model_length_r > LEN_W'(MAX_MODEL_LENGTH)) begin
      len = LEN_W'(MAX_MODEL_LENGTH);
    end else begin
      len = model_length_r;
    end
    // a model not shorter than the row forms no responses and gives no center
    active = COL_W'(len) < width;
  end

  // take a pixel unless a row end waits on a full result register
  assign in_s.ready = !stall;
  assign accept     = in_s.valid && in_s.ready;

  // input stage: column, row and ring pointer, prefix sum, ring write and read
  llrc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel       (in_s.pixel),
    .frame_start (in_s.frame_start),
    .width       (width),
    .len         (len),
    .active      (active),
    .stall       (stall),
    .s1_r        (s1),
    .s1_valid_r  (s1_valid),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr)
  );

  // ring of {pixel, row prefix sum}, indexed by column modulo the ring depth;
  // every entry whose value is used was written earlier in the same row
  llrc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // edge response, running extrema and the row result register
  llrc_extract u_extract (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1        (s1),
    .s1_valid  (s1_valid),
    .ram_rdata (ram_rdata),
    .stall     (stall),
    .out_m     (out_m)
  );

endmodule

/* verif/tb_laser_line_row_center_core.sv */
`timescale 1ns / 100ps

module tb_laser_line_row_center_core;
  import llrc_pkg::*;

  // cycles with no transaction on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // a row result passes the input register, then the output register; plus margin
  localparam int SETTLE_CYCLES  = 4;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_txn_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [IDX_W-1:0] center_col;
    logic             found;
  } row_center_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  llrc_pix_if pix ();
  llrc_res_if res ();

  laser_line_row_center_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (pix),
    .out_m    (res),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pixels waiting for the driver, and row centers waiting for the block
  pix_txn_t    pixel_queue[$];
  row_center_t row_centers[$];

  int   send_idle_pct;
  int   recv_idle_pct;
  int   mismatches = 0;
  int   idle_cycles = 0;
  logic pix_took;

  // ---------------------------------------------------------------------------
  // row center predictor: own copy of registers and per-row state
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]         width_reg;
  logic [LEN_W-1:0]         len_reg;
  logic [PIX_W-1:0]         ring_px [RING_DEPTH];
  logic [COL_W-1:0]         col_cnt;
  logic [ROW_W-1:0]         row_cnt;
  logic signed [RESP_W-1:0] max_v;
  logic signed [RESP_W-1:0] min_v;
  logic [COL_W-1:0]         max_col;
  logic [COL_W-1:0]         min_col;
  logic                     max_ok;
  logic                     min_ok;

  function automatic void clear_extrema();
    col_cnt = '0;
    max_v   = '0;
    min_v   = '0;
    max_col = '0;
    min_col = '0;
    max_ok  = 1'b0;
    min_ok  = 1'b0;
  endfunction

  // column 0 only seeds both extrema, later columns need a strict change
  function automatic void fold_response(input int col, input int v);
    if (col == 0) begin
      max_v = RESP_W'(v);
      min_v = RESP_W'(v);
    end else begin
      if (v > int'(max_v)) begin
        max_v   = RESP_W'(v);
        max_col = COL_W'(col);
        max_ok  = 1'b1;
      end
      if (v < int'(min_v)) begin
        min_v   = RESP_W'(v);
        min_col = COL_W'(col);
        min_ok  = 1'b1;
      end
    end
  endfunction

  function automatic void track_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int          w;
    int          len;
    int          c;
    int          j;
    int          v;
    int          k;
    logic        active;
    row_center_t r;
    // out-of-range registers saturate
    w = int'(width_reg);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    len = int'(len_reg);
    if (len > MAX_MODEL_LENGTH) len = MAX_MODEL_LENGTH;
    active = (len < w);
    // frame start drops any partial row first
    if (fs) begin
      row_cnt = '0;
      clear_extrema();
    end
    c = int'(col_cnt);
    ring_px[c % RING_DEPTH] = px;
    // response of column c - len is complete once column c is in
    if (active && c >= len) begin
      j = c - len;
      v = len * int'(ring_px[j % RING_DEPTH]);
      for (k = 1; k <= len; k++)
        v = v - int'(ring_px[(j + k) % RING_DEPTH]);
      fold_response(j, v);
    end
    if (c >= w - 1) begin
      // first tail column counts as a zero response
      if (active && len >= 1) fold_response(w - len, 0);
      r.found      = active && max_ok && min_ok;
      r.row_index  = row_cnt;
      r.center_col = r.found ? IDX_W'((int'(max_col) + int'(min_col)) / 2) : '0;
      row_centers = {row_centers, r};
      row_cnt = row_cnt + 1'b1;
      clear_extrema();
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic void check_center(input row_center_t got);
    row_center_t want;
    if (row_centers.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: row result with none pending: row %0d center %0d found %0b",
                 $time, got.row_index, got.center_col, got.found);
    end else begin
      want = row_centers.pop_front();
      if (got.row_index !== want.row_index || got.center_col !== want.center_col ||
          got.found !== want.found) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch: exp row %0d col %0d found %0b, act row %0d col %0d found %0b",
                   $time, want.row_index, want.center_col, want.found,
                   got.row_index, got.center_col, got.found);
      end
    end
  endfunction

  // monitor: sample both channels at the rising edge, plus the watchdog
  always @(posedge clk) begin : monitor
    row_center_t got;
    if (!rst_n) begin
      pix_took    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      pix_took <= pix.valid && pix.ready;
      // a result never comes from the pixel of the same edge, so check first
      if (res.valid && res.ready) begin
        got.row_index  = res.row_index;
        got.center_col = res.center_col;
        got.found      = res.found;
        check_center(got);
      end
      if (pix.valid && pix.ready) track_pixel(pix.pixel, pix.frame_start);
      if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // driver: pixel transactions and receiver stalls change at the falling edge
  always @(negedge clk) begin : driver
    pix_txn_t nxt;
    if (!rst_n) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix_took) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pixel_queue.pop_front();
        pix.valid       <= 1'b1;
        pix.pixel       <= nxt.pixel;
        pix.frame_start <= nxt.frame_start;
      end else begin
        pix.valid <= 1'b0;
      end
    end
    res.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_px(input logic [PIX_W-1:0] px, input logic fs);
    pix_txn_t t;
    t.pixel       = px;
    t.frame_start = fs;
    pixel_queue = {pixel_queue, t};
  endfunction

  // one row (or a partial one): mostly a bright stripe on a dark background
  function automatic void push_row(input int n, input logic fs_first);
    int               kind;
    int               pos;
    int               half;
    int               dist_c;
    logic [PIX_W-1:0] lvl;
    logic [PIX_W-1:0] px;
    kind = $urandom_range(9);
    pos  = $urandom_range(n - 1);
    half = $urandom_range(4);
    lvl  = PIX_W'($urandom_range(255));
    for (int i = 0; i < n; i++) begin
      dist_c = (i > pos) ? i - pos : pos - i;
      case (kind)
        6, 7:    px = PIX_W'($urandom_range(255));
        8:       px = lvl;                                  // flat row, no center
        9:       px = ((i + pos) % 2) ? 8'hFF : 8'h00;      // full-swing comb
        default: begin
          if (dist_c <= half) px = PIX_W'($urandom_range(255, 160));
          else px = PIX_W'($urandom_range(40));
        end
      endcase
      push_px(px, fs_first && (i == 0));
    end
  endfunction

  // wait until every pixel is taken and every row center has come back
  task automatic drain();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || pix.valid || row_centers.size() != 0);
    // a partial row may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers back to back, upper bits of the length word are don't-care
  task automatic write_regs(input logic [CFG_W-1:0] w, input logic [LEN_W-1:0] len);
    logic [CFG_W-1:0] len_word;
    len_word = CFG_W'($urandom);
    len_word[LEN_W-1:0] = len;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_ROW_WIDTH;
    cfg_data  <= w;
    width_reg = w;
    @(negedge clk);
    cfg_idx   <= REG_MODEL_LENGTH;
    cfg_data  <= len_word;
    len_reg   = len_word[LEN_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] w_v;
    int               w_eff;
    int               len_v;
    int               rows;
    logic             fs;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_ROW_WIDTH;
    cfg_data        = '0;
    pix.valid       = 1'b0;
    pix.pixel       = '0;
    pix.frame_start = 1'b0;
    res.ready       = 1'b0;
    width_reg       = ROW_WIDTH_RST;
    len_reg         = MODEL_LENGTH_RST;
    foreach (ring_px[i]) ring_px[i] = '0;
    row_cnt = '0;
    clear_extrema();
    send_idle_pct = 28;
    recv_idle_pct = 50;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // width below range acts as 2, length above range saturates: length not below width
    write_regs(12'd0, 7'd127);
    push_px(8'hFF, 1'b1);
    push_px(8'h00, 1'b0);
    drain();

    // narrowest active setting, one extremum only per row
    write_regs(12'd2, 7'd1);
    push_px(8'h00, 1'b1);
    push_px(8'hFF, 1'b0);
    push_px(8'hFF, 1'b0);
    push_px(8'h00, 1'b0);
    drain();

    // zero length gives all-zero responses
    write_regs(12'd4, 7'd0);
    push_px(8'hAA, 1'b1);
    push_px(8'h55, 1'b0);
    push_px(8'hFF, 1'b0);
    push_px(8'h00, 1'b0);
    drain();

    // frame start mid-row drops the partial row
    write_regs(12'd8, 7'd2);
    push_px(8'd7, 1'b1);
    push_px(8'd9, 1'b0);
    push_px(8'd10, 1'b1);
    push_px(8'd10, 1'b0);
    push_px(8'd200, 1'b0);
    push_px(8'd10, 1'b0);
    push_px(8'd10, 1'b0);
    push_px(8'd10, 1'b0);
    push_px(8'd10, 1'b0);
    push_px(8'd10, 1'b0);
    // partial row, then a width shrink ends it on the next pixel
    push_px(8'd0, 1'b0);
    push_px(8'd50, 1'b0);
    push_px(8'd255, 1'b0);
    push_px(8'd50, 1'b0);
    push_px(8'd0, 1'b0);
    drain();
    write_regs(12'd4, 7'd2);
    push_px(8'd30, 1'b0);

    // random settings: receiver-heavy stalls, then sender-heavy, then none
    for (int s = 0; s < 18; s++) begin
      drain();
      if (s == 6) begin
        send_idle_pct = 50;
        recv_idle_pct = 28;
      end
      if (s == 12) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0:       w_v = CFG_W'($urandom_range(1));
        1:       w_v = CFG_W'($urandom_range(300, 100));
        default: w_v = CFG_W'($urandom_range(40, 2));
      endcase
      w_eff = (w_v < 2) ? 2 : int'(w_v);
      case ($urandom_range(7))
        0:       len_v = $urandom_range(127, 65);
        1:       len_v = 0;
        2:       len_v = (w_eff > 64) ? $urandom_range(127, 65) : $urandom_range(w_eff + 3, w_eff);
        default: len_v = $urandom_range((w_eff > 65) ? 64 : w_eff - 1, 1);
      endcase
      write_regs(w_v, LEN_W'(len_v));
      rows = 70 / w_eff + 1;
      fs   = 1'($urandom_range(1));
      for (int r = 0; r < rows; r++) begin
        // occasional broken row cut short by a frame start
        if ($urandom_range(11) == 0) begin
          push_row($urandom_range(w_eff - 1, 1), fs);
          fs = 1'b1;
        end
        push_row(w_eff, fs);
        fs = 1'b0;
      end
      // sometimes leave a row open across the register change
      if ($urandom_range(2) == 0) push_row($urandom_range(w_eff - 1, 1), 1'b0);
    end

    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/llrc_pkg.sv
design/llrc_pix_if.sv
design/llrc_res_if.sv
design/llrc_ram.sv
design/llrc_front.sv
design/llrc_extract.sv
design/laser_line_row_center_core.sv
verif/tb_laser_line_row_center_core.sv
